// File: rtl/qrrs_pkg.sv
// shared constants and types for the quadratic real root solver
`timescale 1ns / 1ps

package qrrs_pkg;

    localparam int COEF_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int FIFO_DEPTH     = 4;

    typedef enum logic [1:0] {
        ST_REAL     = 2'd0,
        ST_A_ZERO   = 2'd1,
        ST_NEG_DISC = 2'd2
    } status_t;

endpackage

// File: rtl/qrrs_front.sv
// front end: coefficient decode, split products and discriminant
`timescale 1ns / 1ps

module qrrs_front #(
    parameter int W = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [W-1:0]         coef_a,
    input  logic [W-1:0]         coef_b,
    input  logic [W-1:0]         coef_c,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [2*W+1:0]       out_d,
    output qrrs_pkg::status_t    out_status,
    output logic                 out_an,
    output logic [W-1:0]         out_am,
    output logic                 out_bn,
    output logic [W-1:0]         out_bm
);
    import qrrs_pkg::*;

    localparam int H  = (W + 1) / 2;
    localparam int PW = 2 * H;
    localparam int DW = 2 * W + 2;

    function automatic logic [W-1:0] mag_of(input logic [W-1:0] v);
        return v[W-1] ? (~v + W'(1)) : v;
    endfunction

    logic en;
    logic v1_reg, v2_reg, v3_reg, v4_reg;

    // stage 1: sign and magnitude
    logic         an1_reg, bn1_reg, cn1_reg;
    logic [W-1:0] am1_reg, bm1_reg, cm1_reg;
    // stage 2: partial products
    logic         an2_reg, bn2_reg, sd2_reg, az2_reg;
    logic [W-1:0] am2_reg, bm2_reg;
    logic [PW-1:0] bhh_reg, bhl_reg, bll_reg, ahh_reg, ahl_reg, alh_reg, all_reg;
    // stage 3: full products
    logic         an3_reg, bn3_reg, sd3_reg, az3_reg;
    logic [W-1:0] am3_reg, bm3_reg;
    logic [2*W-1:0] b2_reg;
    logic [DW-1:0]  ac4_reg;
    // stage 4: discriminant
    logic         an4_reg, bn4_reg;
    logic [W-1:0] am4_reg, bm4_reg;
    logic [DW-1:0] d4_reg;
    status_t      st4_reg;

    logic [2*W-1:0] b2_next, ac_next;
    logic [DW-1:0]  b2e, sum_d;
    logic [DW:0]    diff_d;
    logic [DW-1:0]  d_next;
    status_t        st_next;

    assign en       = out_ready;
    assign in_ready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_comb begin
        b2_next = ((2*W)'(bhh_reg) << (2*H)) + ((2*W)'(bhl_reg) << (H+1))
                + (2*W)'(bll_reg);
        ac_next = ((2*W)'(ahh_reg) << (2*H))
                + (((2*W)'(ahl_reg) + (2*W)'(alh_reg)) << H) + (2*W)'(all_reg);
        b2e     = DW'(b2_reg);
        sum_d   = b2e + ac4_reg;
        diff_d  = {1'b0, b2e} - {1'b0, ac4_reg};
        d_next  = sd3_reg ? sum_d : diff_d[DW-1:0];
        if (az3_reg) begin
            st_next = ST_A_ZERO;
        end else if (!sd3_reg && diff_d[DW]) begin
            st_next = ST_NEG_DISC;
        end else begin
            st_next = ST_REAL;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            an1_reg <= coef_a[W-1];
            bn1_reg <= coef_b[W-1];
            cn1_reg <= coef_c[W-1];
            am1_reg <= mag_of(coef_a);
            bm1_reg <= mag_of(coef_b);
            cm1_reg <= mag_of(coef_c);

            an2_reg <= an1_reg;
            bn2_reg <= bn1_reg;
            sd2_reg <= an1_reg ^ cn1_reg;
            az2_reg <= (am1_reg == '0);
            am2_reg <= am1_reg;
            bm2_reg <= bm1_reg;
            bhh_reg <= PW'(bm1_reg[W-1:H] * bm1_reg[W-1:H]);
            bhl_reg <= PW'(bm1_reg[W-1:H] * bm1_reg[H-1:0]);
            bll_reg <= PW'(bm1_reg[H-1:0] * bm1_reg[H-1:0]);
            ahh_reg <= PW'(am1_reg[W-1:H] * cm1_reg[W-1:H]);
            ahl_reg <= PW'(am1_reg[W-1:H] * cm1_reg[H-1:0]);
            alh_reg <= PW'(am1_reg[H-1:0] * cm1_reg[W-1:H]);
            all_reg <= PW'(am1_reg[H-1:0] * cm1_reg[H-1:0]);

            an3_reg <= an2_reg;
            bn3_reg <= bn2_reg;
            sd3_reg <= sd2_reg;
            az3_reg <= az2_reg;
            am3_reg <= am2_reg;
            bm3_reg <= bm2_reg;
            b2_reg  <= b2_next;
            ac4_reg <= {ac_next, 2'b00};

            an4_reg <= an3_reg;
            bn4_reg <= bn3_reg;
            am4_reg <= am3_reg;
            bm4_reg <= bm3_reg;
            d4_reg  <= d_next;
            st4_reg <= st_next;
        end
    end

    assign out_valid  = v4_reg;
    assign out_d      = d4_reg;
    assign out_status = st4_reg;
    assign out_an     = an4_reg;
    assign out_am     = am4_reg;
    assign out_bn     = bn4_reg;
    assign out_bm     = bm4_reg;
endmodule

// File: rtl/qrrs_fifo.sv
// small queue between the front end and the root pipeline
`timescale 1ns / 1ps

module qrrs_fifo #(
    parameter int DW = 8
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  logic [DW-1:0] wr_data,
    input  logic          pop,
    output logic [DW-1:0] rd_data,
    output logic          full,
    output logic          empty
);
    import qrrs_pkg::*;

    localparam int AW = $clog2(FIFO_DEPTH);
    localparam int CW = $clog2(FIFO_DEPTH + 1);

    logic [DW-1:0] mem_reg [FIFO_DEPTH];
    logic [AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) wr_ptr_reg <= wr_ptr_reg + AW'(1);
            if (pop)  rd_ptr_reg <= rd_ptr_reg + AW'(1);
            if (push && !pop)      count_reg <= count_reg + CW'(1);
            else if (pop && !push) count_reg <= count_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) mem_reg[wr_ptr_reg] <= wr_data;
    end

    assign rd_data = mem_reg[rd_ptr_reg];
    assign full    = (count_reg == CW'(FIFO_DEPTH));
    assign empty   = (count_reg == '0);
endmodule

// File: rtl/qrrs_sqrt.sv
// pipelined integer square root, one root bit per stage
`timescale 1ns / 1ps

module qrrs_sqrt #(
    parameter int DW = 66,
    parameter int SW = 8
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          en,
    input  logic          in_valid,
    input  logic [DW-1:0] in_d,
    input  logic [SW-1:0] in_side,
    output logic          out_valid,
    output logic [DW/2-1:0] out_root,
    output logic [SW-1:0] out_side
);
    localparam int RW  = DW / 2;
    localparam int RMW = RW + 2;

    logic           v_reg    [RW];
    logic [RMW-1:0] rem_reg  [RW];
    logic [RW-1:0]  root_reg [RW];
    logic [DW-1:0]  d_reg    [RW];
    logic [SW-1:0]  side_reg [RW];

    for (genvar k = 0; k < RW; k++) begin : g_stage
        logic           cur_v;
        logic [RMW-1:0] cur_rem;
        logic [RW-1:0]  cur_root;
        logic [DW-1:0]  cur_d;
        logic [SW-1:0]  cur_side;
        logic [RMW+1:0] acc, trial;
        logic           ge;
        logic [RMW-1:0] rem_next;
        logic [RW-1:0]  root_next;

        if (k == 0) begin : g_first
            assign cur_v    = in_valid;
            assign cur_rem  = '0;
            assign cur_root = '0;
            assign cur_d    = in_d;
            assign cur_side = in_side;
        end else begin : g_next
            assign cur_v    = v_reg[k-1];
            assign cur_rem  = rem_reg[k-1];
            assign cur_root = root_reg[k-1];
            assign cur_d    = d_reg[k-1];
            assign cur_side = side_reg[k-1];
        end

        assign acc       = {cur_rem, cur_d[DW-1:DW-2]};
        assign trial     = (RMW+2)'({cur_root, 2'b01});
        assign ge        = (acc >= trial);
        assign rem_next  = ge ? RMW'(acc - trial) : RMW'(acc);
        assign root_next = {cur_root[RW-2:0], ge};

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[k] <= 1'b0;
            end else if (en) begin
                v_reg[k] <= cur_v;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k]  <= rem_next;
                root_reg[k] <= root_next;
                d_reg[k]    <= cur_d << 2;
                side_reg[k] <= cur_side;
            end
        end
    end

    assign out_valid = v_reg[RW-1];
    assign out_root  = root_reg[RW-1];
    assign out_side  = side_reg[RW-1];
endmodule

// File: rtl/qrrs_div.sv
// pipelined restoring divider, two numerators over one divisor
`timescale 1ns / 1ps

module qrrs_div #(
    parameter int NW   = 50,
    parameter int DENW = 33,
    parameter int SW   = 4
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            en,
    input  logic            in_valid,
    input  logic [NW-1:0]   in_num_p,
    input  logic [NW-1:0]   in_num_m,
    input  logic [DENW-1:0] in_den,
    input  logic [SW-1:0]   in_side,
    output logic            out_valid,
    output logic [NW-1:0]   out_q_p,
    output logic [NW-1:0]   out_q_m,
    output logic [SW-1:0]   out_side
);
    logic            v_reg    [NW];
    logic [DENW-1:0] remp_reg [NW];
    logic [DENW-1:0] remm_reg [NW];
    logic [NW-1:0]   nqp_reg  [NW];
    logic [NW-1:0]   nqm_reg  [NW];
    logic [DENW-1:0] den_reg  [NW];
    logic [SW-1:0]   side_reg [NW];

    for (genvar k = 0; k < NW; k++) begin : g_stage
        logic            cur_v;
        logic [DENW-1:0] cur_remp, cur_remm, cur_den;
        logic [NW-1:0]   cur_nqp, cur_nqm;
        logic [SW-1:0]   cur_side;
        logic [DENW:0]   shp, shm, dext;
        logic            gep, gem;

        if (k == 0) begin : g_first
            assign cur_v    = in_valid;
            assign cur_remp = '0;
            assign cur_remm = '0;
            assign cur_nqp  = in_num_p;
            assign cur_nqm  = in_num_m;
            assign cur_den  = in_den;
            assign cur_side = in_side;
        end else begin : g_next
            assign cur_v    = v_reg[k-1];
            assign cur_remp = remp_reg[k-1];
            assign cur_remm = remm_reg[k-1];
            assign cur_nqp  = nqp_reg[k-1];
            assign cur_nqm  = nqm_reg[k-1];
            assign cur_den  = den_reg[k-1];
            assign cur_side = side_reg[k-1];
        end

        assign shp  = {cur_remp, cur_nqp[NW-1]};
        assign shm  = {cur_remm, cur_nqm[NW-1]};
        assign dext = {1'b0, cur_den};
        assign gep  = (shp >= dext);
        assign gem  = (shm >= dext);

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[k] <= 1'b0;
            end else if (en) begin
                v_reg[k] <= cur_v;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                remp_reg[k] <= gep ? DENW'(shp - dext) : DENW'(shp);
                remm_reg[k] <= gem ? DENW'(shm - dext) : DENW'(shm);
                nqp_reg[k]  <= {cur_nqp[NW-2:0], gep};
                nqm_reg[k]  <= {cur_nqm[NW-2:0], gem};
                den_reg[k]  <= cur_den;
                side_reg[k] <= cur_side;
            end
        end
    end

    assign out_valid = v_reg[NW-1];
    assign out_q_p   = nqp_reg[NW-1];
    assign out_q_m   = nqm_reg[NW-1];
    assign out_side  = side_reg[NW-1];
endmodule

// File: rtl/qrrs_back.sv
// back end: square root, numerators, division, clamp and output register
`timescale 1ns / 1ps

module qrrs_back #(
    parameter int W = 32,
    parameter int F = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_pop,
    input  logic [2*W+1:0]       in_d,
    input  qrrs_pkg::status_t    in_status,
    input  logic                 in_an,
    input  logic [W-1:0]         in_am,
    input  logic                 in_bn,
    input  logic [W-1:0]         in_bm,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [W-1:0]         out_root_plus,
    output logic [W-1:0]         out_root_minus,
    output qrrs_pkg::status_t    out_status,
    output logic                 out_sat
);
    import qrrs_pkg::*;

    localparam int DW  = 2 * W + 2;
    localparam int RW  = W + 1;
    localparam int MW  = W + 2;
    localparam int NW  = MW + F;
    localparam int SSW = 2 + 1 + W + 1 + W;

    logic adv;

    // square root stage
    logic           sq_valid;
    logic [RW-1:0]  sq_root;
    logic [SSW-1:0] sq_side;
    status_t        sq_status;
    logic           sq_an, sq_bn;
    logic [W-1:0]   sq_am, sq_bm;

    // numerator stage
    logic          nv_reg;
    status_t       nst_reg;
    logic          nnegp_reg, nnegm_reg;
    logic [NW-1:0] nump_reg, numm_reg;
    logic [W:0]    den_reg;

    logic          pneg, mneg, nb;
    logic [MW-1:0] bme, re, pmag, mmag;

    // divider
    logic          dv_valid;
    logic [NW-1:0] q_p, q_m;
    logic [3:0]    dv_side;
    status_t       dv_status;

    // output register
    logic          m_valid_reg;
    logic [W-1:0]  rp_reg, rm_reg;
    status_t       st_reg;
    logic          sat_reg;

    logic [W:0]    clp, clm;

    function automatic logic [W:0] clamp(input logic [NW-1:0] q, input logic neg);
        logic [NW-1:0] half, lim;
        logic          s;
        logic [W-1:0]  v;
        half = NW'(1) << (W - 1);
        lim  = neg ? half : half - NW'(1);
        s    = (q > lim);
        v    = s ? lim[W-1:0] : q[W-1:0];
        return {s, neg ? (W'(0) - v) : v};
    endfunction

    assign adv    = !m_valid_reg || out_ready;
    assign in_pop = adv && in_valid;

    qrrs_sqrt #(
        .DW (DW),
        .SW (SSW)
    ) u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (in_pop),
        .in_d      (in_d),
        .in_side   ({in_status, in_an, in_am, in_bn, in_bm}),
        .out_valid (sq_valid),
        .out_root  (sq_root),
        .out_side  (sq_side)
    );

    assign sq_status = status_t'(sq_side[SSW-1 -: 2]);
    assign sq_an     = sq_side[2*W+1];
    assign sq_am     = sq_side[2*W:W+1];
    assign sq_bn     = sq_side[W];
    assign sq_bm     = sq_side[W-1:0];

    // signed -b plus or minus the root, as sign and magnitude
    always_comb begin
        bme = MW'(sq_bm);
        re  = MW'(sq_root);
        nb  = (sq_bm != '0) && !sq_bn;
        if (!nb) begin
            pneg = 1'b0;
            pmag = bme + re;
        end else if (bme > re) begin
            pneg = 1'b1;
            pmag = bme - re;
        end else begin
            pneg = 1'b0;
            pmag = re - bme;
        end
        if (nb || sq_bm == '0) begin
            mneg = 1'b1;
            mmag = bme + re;
        end else if (bme >= re) begin
            mneg = 1'b0;
            mmag = bme - re;
        end else begin
            mneg = 1'b1;
            mmag = re - bme;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nv_reg <= 1'b0;
        end else if (adv) begin
            nv_reg <= sq_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            nst_reg   <= sq_status;
            nnegp_reg <= pneg ^ sq_an;
            nnegm_reg <= mneg ^ sq_an;
            nump_reg  <= NW'(pmag) << F;
            numm_reg  <= NW'(mmag) << F;
            den_reg   <= {sq_am, 1'b0};
        end
    end

    qrrs_div #(
        .NW   (NW),
        .DENW (W + 1),
        .SW   (4)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (nv_reg),
        .in_num_p  (nump_reg),
        .in_num_m  (numm_reg),
        .in_den    (den_reg),
        .in_side   ({nst_reg, nnegp_reg, nnegm_reg}),
        .out_valid (dv_valid),
        .out_q_p   (q_p),
        .out_q_m   (q_m),
        .out_side  (dv_side)
    );

    assign dv_status = status_t'(dv_side[3:2]);
    assign clp       = clamp(q_p, dv_side[1]);
    assign clm       = clamp(q_m, dv_side[0]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= dv_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            st_reg <= dv_status;
            if (dv_status == ST_REAL) begin
                rp_reg  <= clp[W-1:0];
                rm_reg  <= clm[W-1:0];
                sat_reg <= clp[W] | clm[W];
            end else begin
                rp_reg  <= '0;
                rm_reg  <= '0;
                sat_reg <= 1'b0;
            end
        end
    end

    assign out_valid      = m_valid_reg;
    assign out_root_plus  = rp_reg;
    assign out_root_minus = rm_reg;
    assign out_status     = st_reg;
    assign out_sat        = sat_reg;
endmodule

// File: rtl/quadratic_real_root_solver.sv
// top level of the quadratic real root solver
`timescale 1ns / 1ps

// Solves a*x^2 + b*x + c = 0 for signed fixed-point coefficients (COEF_WIDTH
// bits, FRAC_BITS fraction bits) and returns both real roots, rounded toward
// zero and clamped to the coefficient range, with a flag when either was
// clamped. Status is 0 for real roots, 1 when a is zero and 2 when the
// discriminant is negative; roots and flag read zero unless status is 0.
// One coefficient set is taken per cycle while the queue has room, and
// results leave in order, one per cycle while m_tready is held high. The
// pipeline is four front stages for decode, products and discriminant,
// the queue, one stage per square root bit, a numerator stage, one stage
// per quotient bit and the output register. The front end only stalls
// when the four-entry queue is full; the back end stalls as a whole while
// the output holds an untaken result.

module quadratic_real_root_solver #(
    parameter int COEF_WIDTH = qrrs_pkg::COEF_WIDTH_DEF,
    parameter int FRAC_BITS  = qrrs_pkg::FRAC_BITS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // coef_a, coef_b, coef_c from bit 0 up, zero padded to bytes
    input  logic [((3*COEF_WIDTH+7)/8)*8-1:0]    s_tdata,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // root_plus, root_minus from bit 0 up, zero padded to bytes
    output logic [((2*COEF_WIDTH+7)/8)*8-1:0]    m_tdata,
    // status (2 bits), saturated from bit 0 up
    output logic [2:0]                           m_tuser,
    output logic                                 m_tvalid,
    input  logic                                 m_tready
);
    import qrrs_pkg::*;

    localparam int W   = COEF_WIDTH;
    localparam int DW  = 2 * W + 2;
    localparam int QW  = DW + 2 + 1 + W + 1 + W;
    localparam int MDW = ((2 * W + 7) / 8) * 8;

    // front to queue
    logic           fr_valid, q_full, q_empty, q_pop, fr_push;
    logic [DW-1:0]  fr_d;
    status_t        fr_status;
    logic           fr_an, fr_bn;
    logic [W-1:0]   fr_am, fr_bm;
    logic [QW-1:0]  q_rd;

    // back end results
    logic [W-1:0]   root_plus, root_minus;
    status_t        status;
    logic           saturated;

    qrrs_front #(
        .W (W)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .coef_a     (s_tdata[W-1:0]),
        .coef_b     (s_tdata[2*W-1:W]),
        .coef_c     (s_tdata[3*W-1:2*W]),
        .out_valid  (fr_valid),
        .out_ready  (!q_full),
        .out_d      (fr_d),
        .out_status (fr_status),
        .out_an     (fr_an),
        .out_am     (fr_am),
        .out_bn     (fr_bn),
        .out_bm     (fr_bm)
    );

    // the front stages move only when the queue has room
    assign fr_push = fr_valid && !q_full;

    qrrs_fifo #(
        .DW (QW)
    ) u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (fr_push),
        .wr_data ({fr_d, fr_status, fr_an, fr_am, fr_bn, fr_bm}),
        .pop     (q_pop),
        .rd_data (q_rd),
        .full    (q_full),
        .empty   (q_empty)
    );

    qrrs_back #(
        .W (W),
        .F (FRAC_BITS)
    ) u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .in_valid       (!q_empty),
        .in_pop         (q_pop),
        .in_d           (q_rd[QW-1 -: DW]),
        .in_status      (status_t'(q_rd[2*W+3:2*W+2])),
        .in_an          (q_rd[2*W+1]),
        .in_am          (q_rd[2*W:W+1]),
        .in_bn          (q_rd[W]),
        .in_bm          (q_rd[W-1:0]),
        .out_valid      (m_tvalid),
        .out_ready      (m_tready),
        .out_root_plus  (root_plus),
        .out_root_minus (root_minus),
        .out_status     (status),
        .out_sat        (saturated)
    );

    // result transfer packing
    assign m_tdata = MDW'({root_minus, root_plus});
    assign m_tuser = {saturated, status};
endmodule
